[src/bbpe_pkg.sv]
// ----------------------------------------------------------------------------
// bbpe_pkg
// Types and constants shared by the biquadratic bezier patch evaluator.
// ----------------------------------------------------------------------------
package bbpe_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int CP_WIDTH     = 36;
   localparam int COORD_WIDTH  = 17;
   localparam int INDEX_WIDTH  = 4;
   localparam int GRID_POINTS  = 9;

   localparam logic [COORD_WIDTH-1:0] ONE_Q16 = COORD_WIDTH'(65536);

   localparam logic signed [SAMPLE_WIDTH-1:0] SURF_MAX = 32'sh7fff_ffff;
   localparam logic signed [SAMPLE_WIDTH-1:0] SURF_MIN = 32'sh8000_0000;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EVAL = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic [INDEX_WIDTH-1:0]         sample_index;
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
      logic [COORD_WIDTH-1:0]         u_coord;
      logic [COORD_WIDTH-1:0]         v_coord;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] surface_value;
      logic                           saturated;
   } rsp_type;

endpackage

[src/biquadratic_bezier_patch_eval.sv]
// A load transfer writes one of the nine Q15.16 samples (positions above 8 are
// dropped) and then rebuilds the control points in an edge step and a centre
// step, and returns nothing. On an evaluate transfer one multiply-accumulate
// unit does 4 weight squares, 9 row products and 3 column products, one per
// cycle; a done step forms the rounded, saturated result, holding while the
// output register is still full. req_ready is high only while the sequencer is
// idle; a finished result waits in an output register, so the next item may be
// taken before the previous result is drained.
// ----------------------------------------------------------------------------
// biquadratic_bezier_patch_eval
// Sample store, control-point rebuild and sequenced Bernstein evaluation.
// ----------------------------------------------------------------------------
module biquadratic_bezier_patch_eval (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bbpe_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbpe_pkg::rsp_type rsp_payload
);
   import bbpe_pkg::*;

   localparam int MUL_A_WIDTH = 40;
   localparam int MUL_B_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int FRAC_BITS   = 16;
   localparam int WIDE_WIDTH  = CP_WIDTH + 2;

   localparam logic signed [PROD_WIDTH-1:0] HALF_LSB = PROD_WIDTH'(32768);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_CENTRE,
      ST_WEIGHT,
      ST_ROW,
      ST_RSUM,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic signed [SAMPLE_WIDTH-1:0] samples_ff [GRID_POINTS];
   logic signed [SAMPLE_WIDTH-1:0] samples_in [GRID_POINTS];
   logic signed [CP_WIDTH-1:0]     cp_ff [GRID_POINTS];
   logic signed [CP_WIDTH-1:0]     cp_in [GRID_POINTS];
   logic [COORD_WIDTH-1:0]         u_ff, u_in, v_ff, v_in;
   logic [COORD_WIDTH-1:0]         wu0_ff, wu0_in, wu2_ff, wu2_in;
   logic [COORD_WIDTH-1:0]         wv0_ff, wv0_in, wv2_ff, wv2_in;
   logic [1:0]                     i_ff, i_in, j_ff, j_in;
   logic signed [PROD_WIDTH-1:0]   row_acc_ff, row_acc_in;
   logic signed [PROD_WIDTH-1:0]   total_ff, total_in;
   rsp_type                        rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [COORD_WIDTH-1:0]         cu, cv, wu1, wv1, wu_sel, wv_sel;
   logic [INDEX_WIDTH-1:0]         cp_idx;
   logic signed [PROD_WIDTH-1:0]   row_sum, total_sum, res_wide;
   logic signed [MUL_A_WIDTH-1:0]  row_round;
   logic signed [MUL_A_WIDTH-1:0]  mul_a;
   logic signed [MUL_B_WIDTH-1:0]  mul_b;
   logic signed [PROD_WIDTH-1:0]   product;
   logic signed [WIDE_WIDTH-1:0]   edge_sum, corner_sum, centre_x4, centre;
   logic                           over_pos, over_neg;

   // 2*mid - floor((a+b)/2)
   function automatic logic signed [CP_WIDTH-1:0] edge_point(
      input logic signed [SAMPLE_WIDTH-1:0] mid,
      input logic signed [SAMPLE_WIDTH-1:0] a,
      input logic signed [SAMPLE_WIDTH-1:0] b
   );
      logic signed [SAMPLE_WIDTH+1:0] twice;
      logic signed [SAMPLE_WIDTH+1:0] pair;
      logic signed [SAMPLE_WIDTH+1:0] diff;
      twice = {mid[SAMPLE_WIDTH-1], mid, 1'b0};
      pair  = {{2{a[SAMPLE_WIDTH-1]}}, a} + {{2{b[SAMPLE_WIDTH-1]}}, b};
      diff  = twice - (pair >>> 1);
      edge_point = {{(CP_WIDTH-SAMPLE_WIDTH-2){diff[SAMPLE_WIDTH+1]}}, diff};
   endfunction

   function automatic logic signed [WIDE_WIDTH-1:0] widen(
      input logic signed [CP_WIDTH-1:0] x
   );
      widen = {{(WIDE_WIDTH-CP_WIDTH){x[CP_WIDTH-1]}}, x};
   endfunction

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // bernstein weights, middle one makes the three sum to one
   assign cu  = ONE_Q16 - u_ff;
   assign cv  = ONE_Q16 - v_ff;
   assign wu1 = ONE_Q16 - wu0_ff - wu2_ff;
   assign wv1 = ONE_Q16 - wv0_ff - wv2_ff;

   assign cp_idx = {2'b00, i_ff} + {2'b00, i_ff} + {2'b00, i_ff} + {2'b00, j_ff};

   always_comb begin
      case (j_ff)
         2'd0:    wv_sel = wv0_ff;
         2'd1:    wv_sel = wv1;
         default: wv_sel = wv2_ff;
      endcase
      case (i_ff)
         2'd0:    wu_sel = wu0_ff;
         2'd1:    wu_sel = wu1;
         default: wu_sel = wu2_ff;
      endcase
   end

   assign row_sum   = row_acc_ff + HALF_LSB;
   assign row_round = MUL_A_WIDTH'(row_sum >>> FRAC_BITS);
   assign total_sum = total_ff + HALF_LSB;
   assign res_wide  = total_sum >>> FRAC_BITS;
   assign over_pos  = !res_wide[PROD_WIDTH-1] && (|res_wide[PROD_WIDTH-2:SAMPLE_WIDTH-1]);
   assign over_neg  = res_wide[PROD_WIDTH-1] && !(&res_wide[PROD_WIDTH-2:SAMPLE_WIDTH-1]);

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_WEIGHT: begin
            case (j_ff)
               2'd0: begin
                  mul_a = {{(MUL_A_WIDTH-COORD_WIDTH){1'b0}}, cu};
                  mul_b = {1'b0, cu};
               end
               2'd1: begin
                  mul_a = {{(MUL_A_WIDTH-COORD_WIDTH){1'b0}}, u_ff};
                  mul_b = {1'b0, u_ff};
               end
               2'd2: begin
                  mul_a = {{(MUL_A_WIDTH-COORD_WIDTH){1'b0}}, cv};
                  mul_b = {1'b0, cv};
               end
               default: begin
                  mul_a = {{(MUL_A_WIDTH-COORD_WIDTH){1'b0}}, v_ff};
                  mul_b = {1'b0, v_ff};
               end
            endcase
         end
         ST_ROW: begin
            mul_a = {{(MUL_A_WIDTH-CP_WIDTH){cp_ff[cp_idx][CP_WIDTH-1]}}, cp_ff[cp_idx]};
            mul_b = {1'b0, wv_sel};
         end
         ST_RSUM: begin
            mul_a = row_round;
            mul_b = {1'b0, wu_sel};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   // centre point from the registered edges and corners
   assign edge_sum   = widen(cp_ff[1]) + widen(cp_ff[3]) + widen(cp_ff[5]) + widen(cp_ff[7]);
   assign corner_sum = widen(cp_ff[0]) + widen(cp_ff[2]) + widen(cp_ff[6]) + widen(cp_ff[8]);
   assign centre_x4  = {{(WIDE_WIDTH-SAMPLE_WIDTH-2){samples_ff[4][SAMPLE_WIDTH-1]}},
                        samples_ff[4], 2'b00};
   assign centre     = centre_x4 - (edge_sum >>> 1) - (corner_sum >>> 2);

   always_comb begin
      state_in     = state_ff;
      samples_in   = samples_ff;
      cp_in        = cp_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      wu0_in       = wu0_ff;
      wu2_in       = wu2_ff;
      wv0_in       = wv0_ff;
      wv2_in       = wv2_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      row_acc_in   = row_acc_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.kind == KIND_LOAD) begin
                  if (req_payload.sample_index < INDEX_WIDTH'(GRID_POINTS)) begin
                     samples_in[req_payload.sample_index] = req_payload.sample_value;
                  end
                  state_in = ST_EDGE;
               end else begin
                  u_in       = (req_payload.u_coord > ONE_Q16) ? ONE_Q16 : req_payload.u_coord;
                  v_in       = (req_payload.v_coord > ONE_Q16) ? ONE_Q16 : req_payload.v_coord;
                  i_in       = 2'd0;
                  j_in       = 2'd0;
                  row_acc_in = '0;
                  total_in   = '0;
                  state_in   = ST_WEIGHT;
               end
            end
         end
         ST_EDGE: begin
            cp_in[0] = {{(CP_WIDTH-SAMPLE_WIDTH){samples_ff[0][SAMPLE_WIDTH-1]}}, samples_ff[0]};
            cp_in[2] = {{(CP_WIDTH-SAMPLE_WIDTH){samples_ff[2][SAMPLE_WIDTH-1]}}, samples_ff[2]};
            cp_in[6] = {{(CP_WIDTH-SAMPLE_WIDTH){samples_ff[6][SAMPLE_WIDTH-1]}}, samples_ff[6]};
            cp_in[8] = {{(CP_WIDTH-SAMPLE_WIDTH){samples_ff[8][SAMPLE_WIDTH-1]}}, samples_ff[8]};
            cp_in[1] = edge_point(samples_ff[1], samples_ff[0], samples_ff[2]);
            cp_in[3] = edge_point(samples_ff[3], samples_ff[0], samples_ff[6]);
            cp_in[5] = edge_point(samples_ff[5], samples_ff[2], samples_ff[8]);
            cp_in[7] = edge_point(samples_ff[7], samples_ff[6], samples_ff[8]);
            state_in = ST_CENTRE;
         end
         ST_CENTRE: begin
            cp_in[4] = centre[CP_WIDTH-1:0];
            state_in = ST_IDLE;
         end
         ST_WEIGHT: begin
            // j steps through cu^2, u^2, cv^2, v^2
            case (j_ff)
               2'd0:    wu0_in = product[COORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
               2'd1:    wu2_in = product[COORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
               2'd2:    wv0_in = product[COORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
               default: wv2_in = product[COORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
            endcase
            if (j_ff == 2'd3) begin
               j_in     = 2'd0;
               state_in = ST_ROW;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         ST_ROW: begin
            row_acc_in = row_acc_ff + product;
            if (j_ff == 2'd2) begin
               state_in = ST_RSUM;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         ST_RSUM: begin
            total_in   = total_ff + product;
            row_acc_in = '0;
            j_in       = 2'd0;
            if (i_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + 2'd1;
               state_in = ST_ROW;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.saturated = over_pos || over_neg;
               if (over_pos) begin
                  rsp_in.surface_value = SURF_MAX;
               end else if (over_neg) begin
                  rsp_in.surface_value = SURF_MIN;
               end else begin
                  rsp_in.surface_value = res_wide[SAMPLE_WIDTH-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < GRID_POINTS; k++) begin
            samples_ff[k] <= '0;
            cp_ff[k]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         samples_ff   <= samples_in;
         cp_ff        <= cp_in;
      end
      u_ff       <= u_in;
      v_ff       <= v_in;
      wu0_ff     <= wu0_in;
      wu2_ff     <= wu2_in;
      wv0_ff     <= wv0_in;
      wv2_ff     <= wv2_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      row_acc_ff <= row_acc_in;
      total_ff   <= total_in;
      rsp_ff     <= rsp_in;
   end

   a_load_rebuilds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.kind == KIND_LOAD |=> state_ff == ST_EDGE)
      else $error("load transfer did not start the control point rebuild");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.kind == KIND_EVAL |=> state_ff == ST_WEIGHT)
      else $error("evaluate transfer did not start the weight pass");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the done step");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.saturated |->
         rsp_payload.surface_value == SURF_MAX || rsp_payload.surface_value == SURF_MIN)
      else $error("saturated result not clamped");

   a_row_complete: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RSUM |-> $past(state_ff) == ST_ROW && $past(j_ff) == 2'd2)
      else $error("row sum taken before three row products");

endmodule
